// File: sv/tbcd_pkg.sv
// Shared types and constants for the three-bit code dictionary unpacker.
// No dependencies; every other file of the block imports this package.
package tbcd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodeW      = 3;
  localparam int unsigned CodesMax   = 3;
  localparam int unsigned NumW       = 2;
  localparam int unsigned DictW      = 64;
  localparam int unsigned LimitW     = 32;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned QueueDepth = 2;

  // Position of a byte inside its three-byte group.
  typedef enum logic [1:0] {
    PH0 = 2'd0,
    PH1 = 2'd1,
    PH2 = 2'd2
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_DICT  = 1'b0,
    REG_LIMIT = 1'b1
  } cfg_reg_e;

  // One decoded byte: up to three codes and how many of them produce output.
  typedef struct packed {
    logic [CodesMax-1:0][CodeW-1:0] codes;
    logic [NumW-1:0]                num;
  } job_t;

endpackage

// File: sv/tbcd_front.sv
// Front end of the unpacker: accepts packed bytes, splits them into codes
// and decides how many characters each byte may still emit. Uses tbcd_pkg.
module tbcd_front import tbcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  in_byte_i,
  input  logic [LimitW-1:0] limit_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output job_t              job_o
);

  phase_e                         phase_q, phase_d;
  logic [CodeW-1:0]               carry_q, carry_d;
  logic [LimitW-1:0]              count_q, count_d;
  logic [CodesMax-1:0][CodeW-1:0] codes;
  logic [NumW-1:0]                ncodes;
  logic [NumW-1:0]                avail;
  logic [NumW-1:0]                num;
  logic [LimitW-1:0]              diff;
  logic                           accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Code extraction; an out-of-range phase behaves as the first phase.
  always_comb begin
    codes   = '0;
    ncodes  = NumW'(3);
    carry_d = '0;
    phase_d = PH0;
    unique case (phase_q)
      PH1: begin
        codes[0] = carry_q | {2'b00, in_byte_i[7]};
        codes[1] = in_byte_i[6:4];
        codes[2] = in_byte_i[3:1];
        carry_d  = {in_byte_i[0], 2'b00};
        phase_d  = PH2;
      end
      PH2: begin
        codes[0] = carry_q | {1'b0, in_byte_i[7:6]};
        codes[1] = in_byte_i[5:3];
        codes[2] = in_byte_i[2:0];
        carry_d  = '0;
        phase_d  = PH0;
      end
      default: begin
        codes[0] = in_byte_i[7:5];
        codes[1] = in_byte_i[4:2];
        ncodes   = NumW'(2);
        carry_d  = {in_byte_i[1:0], 1'b0};
        phase_d  = PH1;
      end
    endcase
  end

  // Remaining budget, saturated at three characters.
  always_comb begin
    diff = limit_i - count_q;
    if (count_q >= limit_i) begin
      avail = '0;
    end else if (diff >= LimitW'(CodesMax)) begin
      avail = NumW'(CodesMax);
    end else begin
      avail = diff[NumW-1:0];
    end
    num     = (avail < ncodes) ? avail : ncodes;
    count_d = count_q + LimitW'(num);
  end

  assign job_o  = '{codes: codes, num: num};
  assign push_o = accept && (num != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH0;
      carry_q <= '0;
      count_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
      count_q <= count_d;
    end
  end

  a_count_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= $past(count_q)) else $error("emitted count went backwards");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q)) else $error("count moved without a byte");

endmodule

// File: sv/tbcd_fifo.sv
// Short queue of decoded jobs between the front and back ends.
// Uses job_t from tbcd_pkg.
module tbcd_fifo import tbcd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  job_t             mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d;
  logic [AddrW-1:0] rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = (wr_q == AddrW'(Depth - 1)) ? '0 : wr_q + AddrW'(1);
    rd_d  = (rd_q == AddrW'(Depth - 1)) ? '0 : rd_q + AddrW'(1);
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_d;
      end
      if (pop_i) begin
        rd_q <= rd_d;
      end
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("job queue underflow");

  a_nonempty_jobs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> data_o.num != '0) else $error("queued job carries no output");

endmodule

// File: sv/tbcd_back.sv
// Back end of the unpacker: walks the codes of the head job, looks each one
// up in the dictionary and drives the registered output. Uses tbcd_pkg.
module tbcd_back import tbcd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  job_t                       job_i,
  output logic                       pop_o,
  input  logic [7:0][ByteW-1:0]      dict_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ByteW-1:0]           out_char_o,
  output logic                       out_last_o
);

  logic [NumW-1:0]  idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_char_q;
  logic             out_last_q;
  logic             advance;
  logic             is_last;
  logic [CodeW-1:0] code;

  assign advance = job_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (idx_q == job_i.num - NumW'(1));
  assign code    = job_i.codes[idx_q];
  assign pop_o   = advance && is_last;

  always_comb begin
    idx_d = idx_q;
    if (advance) begin
      idx_d = is_last ? '0 : idx_q + NumW'(1);
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_char_q <= dict_i[code];
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q < job_i.num) else $error("code index beyond job");

endmodule

// File: sv/three_bit_code_dictionary_unpacker.sv
// Top level of the three-bit code dictionary unpacker: config registers,
// front end, job queue and back end. Depends on tbcd_pkg and its submodules.
// The first character of a byte is registered in the job queue and then in
// the output register of the back end. The output carries one character
// per cycle while the sink is ready; the single output port of the back
// end sets this rate. Reset clears the phase, carry and emitted count, both
// config registers and the queue; no clearing pass.
module three_bit_code_dictionary_unpacker import tbcd_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DictW-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [ByteW-1:0]   s_axis_tdata_i,   // [7:0] packed_byte
  // Output stream.
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [ByteW-1:0]   m_axis_tdata_o,   // [7:0] out_char
  output logic               m_axis_tlast_o    // last_of_run
);

  // The dictionary holds eight one-byte entries, entry k in byte lane k.
  logic [7:0][ByteW-1:0] dict_q;
  logic [LimitW-1:0]     limit_q;

  logic queue_full;
  logic push;
  logic pop;
  logic job_valid;
  job_t job_in;
  job_t job_head;

  // Configuration registers. The user must make writes only while the block
  // is idle, not enforced here; the front end reads the limit unshadowed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dict_q  <= '0;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_DICT:  dict_q  <= cfg_wdata_i;
        REG_LIMIT: limit_q <= cfg_wdata_i[LimitW-1:0];
        default:   ;
      endcase
    end
  end

  // The front end splits each byte into codes and trims them to the
  // remaining character budget; bytes with nothing to emit never queue.
  tbcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .limit_i      (limit_q),
    .queue_full_i (queue_full),
    .push_o       (push),
    .job_o        (job_in)
  );

  // The queue lets the front keep taking bytes while the back end drains.
  tbcd_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .data_o  (job_head)
  );

  // Back end emits one character per cycle from the head job unless stalled.
  tbcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .dict_i      (dict_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_char_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
